### hdl/multibuffer_sample_playback_mixer_macros.svh
`ifndef MULTIBUFFER_SAMPLE_PLAYBACK_MIXER_MACROS_SVH
`define MULTIBUFFER_SAMPLE_PLAYBACK_MIXER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define MSP_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define MSP_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hdl/msp_pkg.sv
package msp_pkg;

	localparam int NUM_BUFFERS  = 4;
	localparam int BUFFER_DEPTH = 16384;
	localparam int FRAC_BITS    = 12;
	localparam int MIX_SHIFT    = 3;

	localparam int MODE_W     = 2;
	localparam int SEL_W      = 2;
	localparam int ADDR_W     = 14;
	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 16;
	localparam int VOL_W      = 9;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// input item kinds
	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COMMIT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_STEP   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_PAUSED = 2'd2;

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd4096;
	localparam logic [VOL_W-1:0]  VOL_RESET  = 9'd256;

	// gain is volume / 64
	localparam int VOL_SHIFT = 6;

	localparam int                  OFFSET_BASE = 32'h8000;
	localparam logic [SAMPLE_W-1:0] OUT_MAX     = 16'hffff;
	localparam logic [SAMPLE_W-1:0] SIGN_FLIP   = 16'h8000;

	typedef struct packed {
		logic             tick;
		logic             audible;
		logic             playing;
		logic [SEL_W-1:0] cur_buf;
	} tick_t;

endpackage

### hdl/msp_if.sv
interface msp_in_if;
	logic                                valid;
	logic                                ready;
	logic [msp_pkg::MODE_W-1:0]          mode;
	logic [msp_pkg::SEL_W-1:0]           buffer_select;
	logic [msp_pkg::ADDR_W-1:0]          sample_address;
	logic signed [msp_pkg::SAMPLE_W-1:0] sample_value;

	modport source (output valid, mode, buffer_select, sample_address, sample_value,
		input ready);
	modport sink (input valid, mode, buffer_select, sample_address, sample_value,
		output ready);
endinterface

interface msp_out_if;
	logic                         valid;
	logic                         ready;
	logic [msp_pkg::SAMPLE_W-1:0] sample_out;
	logic                         playing;
	logic [msp_pkg::SEL_W-1:0]    current_buffer;

	modport source (output valid, sample_out, playing, current_buffer, input ready);
	modport sink (input valid, sample_out, playing, current_buffer, output ready);
endinterface

interface msp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [msp_pkg::CFG_ADDR_W-1:0] addr;
	logic [msp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

### hdl/msp_ram.sv
module msp_ram #(
	parameter int WIDTH = msp_pkg::SAMPLE_W,
	parameter int DEPTH = msp_pkg::NUM_BUFFERS * msp_pkg::BUFFER_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/msp_ctrl.sv
module msp_ctrl #(
	parameter int NUM_BUFFERS  = msp_pkg::NUM_BUFFERS,
	parameter int BUFFER_DEPTH = msp_pkg::BUFFER_DEPTH,
	parameter int FRAC_BITS    = msp_pkg::FRAC_BITS,
	localparam int STORE_AW    = $clog2(NUM_BUFFERS * BUFFER_DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	msp_in_if.sink                      items,
	msp_cfg_if.sink                     cfg,
	input  logic                        adv,
	output msp_pkg::tick_t              tick_s1,
	output logic [msp_pkg::VOL_W-1:0]   vol,
	output logic                        ram_we,
	output logic [STORE_AW-1:0]         ram_waddr,
	output logic                        ram_re,
	output logic [STORE_AW-1:0]         ram_raddr
);

	localparam int    BUF_W   = $clog2(NUM_BUFFERS);
	localparam int    IDX_W   = $clog2(BUFFER_DEPTH);
	localparam longint BUF_LEN = longint'(BUFFER_DEPTH) << FRAC_BITS;
	localparam int    POS_W   = $clog2(BUF_LEN + (longint'(1) << msp_pkg::STEP_W));

	localparam logic [POS_W-1:0]    LEN_C   = POS_W'(BUF_LEN);
	localparam logic [STORE_AW-1:0] DEPTH_C = STORE_AW'(BUFFER_DEPTH);
	localparam logic [BUF_W-1:0]    LAST_C  = BUF_W'(NUM_BUFFERS - 1);

	logic [msp_pkg::STEP_W-1:0] step_q;
	logic [msp_pkg::VOL_W-1:0]  vol_q;
	logic                       paused_q;

	logic [NUM_BUFFERS-1:0] full_q, full_n;
	logic [BUF_W-1:0]       pb_q, pb_n, nb, sel_b;
	logic [POS_W-1:0]       pos_q, pos_n, pos_rd, end_cur, end_nxt, pos_sub;
	logic                   active_q, active_n;
	logic                   accept, sel_ok, addr_ok, full_sel, audible, wrap, cont;
	logic [IDX_W-1:0]       idx;

	// configuration writes always land at once
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= msp_pkg::STEP_RESET;
			vol_q    <= msp_pkg::VOL_RESET;
			paused_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.addr)
				msp_pkg::CFG_STEP:   step_q   <= cfg.data;
				msp_pkg::CFG_VOLUME: vol_q    <= cfg.data[msp_pkg::VOL_W-1:0];
				msp_pkg::CFG_PAUSED: paused_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign vol = vol_q;

	// take a new item whenever stage one is empty or drains this cycle
	assign items.ready = !tick_s1.tick || adv;
	assign accept      = items.valid && items.ready;

	assign sel_b    = BUF_W'(items.buffer_select);
	assign sel_ok   = 32'(items.buffer_select) < NUM_BUFFERS;
	assign addr_ok  = 32'(items.sample_address) < BUFFER_DEPTH;
	assign full_sel = sel_ok && full_q[sel_b];

	assign nb      = (pb_q == LAST_C) ? '0 : pb_q + 1'b1;
	assign end_cur = full_q[pb_q] ? LEN_C : '0;
	assign end_nxt = full_q[nb] ? LEN_C : '0;
	assign wrap    = pos_q >= end_cur;
	assign pos_sub = pos_q - end_cur;
	assign cont    = pos_sub < end_nxt;

	always_comb begin
		full_n   = full_q;
		pb_n     = pb_q;
		pos_n    = pos_q;
		active_n = active_q;
		pos_rd   = pos_q;
		audible  = 1'b0;
		case (items.mode)
			msp_pkg::MODE_COMMIT: begin
				if (sel_ok && !full_sel) begin
					full_n[sel_b] = 1'b1;
					if (!active_q) begin
						pb_n     = sel_b;
						active_n = 1'b1;
					end
				end
			end
			msp_pkg::MODE_TICK: begin
				if (active_q && !paused_q) begin
					if (wrap) begin
						// current buffer is used up: release it and move on
						full_n[pb_q] = 1'b0;
						pb_n         = nb;
						if (cont) begin
							pos_rd  = pos_sub;
							audible = 1'b1;
						end else begin
							full_n[nb] = 1'b0;
							pos_n      = '0;
							active_n   = 1'b0;
						end
					end else begin
						audible = 1'b1;
					end
					if (audible) begin
						pos_n = pos_rd + POS_W'(step_q);
					end
				end
			end
			default: ;
		endcase
	end

	assign idx = pos_rd[FRAC_BITS +: IDX_W];

	assign ram_we    = accept && (items.mode == msp_pkg::MODE_WRITE) && sel_ok && addr_ok
		&& !full_sel;
	assign ram_waddr = STORE_AW'(sel_b) * DEPTH_C + STORE_AW'(items.sample_address);
	assign ram_re    = items.ready;
	assign ram_raddr = STORE_AW'(pb_n) * DEPTH_C + STORE_AW'(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q   <= '0;
			pb_q     <= '0;
			pos_q    <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			full_q   <= full_n;
			pb_q     <= pb_n;
			pos_q    <= pos_n;
			active_q <= active_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1 <= '0;
		end else if (items.ready) begin
			tick_s1.tick    <= accept && (items.mode == msp_pkg::MODE_TICK);
			tick_s1.audible <= audible;
			tick_s1.playing <= active_n;
			tick_s1.cur_buf <= msp_pkg::SEL_W'(pb_n);
		end
	end

endmodule

### hdl/msp_mix.sv
module msp_mix #(
	parameter int MIX_SHIFT = msp_pkg::MIX_SHIFT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  msp_pkg::tick_t               tick_s1,
	input  logic [msp_pkg::SAMPLE_W-1:0] rd_data,
	input  logic [msp_pkg::VOL_W-1:0]    vol,
	output logic                         adv,
	msp_out_if.source                    results
);

	localparam int PROD_W   = msp_pkg::SAMPLE_W + msp_pkg::VOL_W + 1;
	localparam int SCALED_W = PROD_W - msp_pkg::VOL_SHIFT;
	localparam int OFS_W    = msp_pkg::SAMPLE_W + MIX_SHIFT + 1;
	localparam int MIX_W    = ((SCALED_W > OFS_W) ? SCALED_W : OFS_W) + 1;

	localparam logic signed [PROD_W-1:0] ROUND_C  = PROD_W'((1 << msp_pkg::VOL_SHIFT) - 1);
	localparam logic signed [MIX_W-1:0]  OFFSET_C =
		MIX_W'(longint'(msp_pkg::OFFSET_BASE) << MIX_SHIFT);
	localparam logic signed [MIX_W-1:0]  MAX_C    = MIX_W'(msp_pkg::OUT_MAX);

	logic signed [PROD_W-1:0]     prod, biased;
	logic signed [SCALED_W-1:0]   scaled;
	logic signed [MIX_W-1:0]      mix, shifted;
	logic [msp_pkg::SAMPLE_W-1:0] word;
	logic                         valid_q;
	logic [msp_pkg::SAMPLE_W-1:0] sample_q;
	logic                         playing_q;
	logic [msp_pkg::SEL_W-1:0]    cur_q;

	assign adv = !valid_q || results.ready;

	// divide by 64 toward zero: bias negative products before the shift
	assign prod   = $signed(rd_data) * $signed({1'b0, vol});
	assign biased = prod + (prod[PROD_W-1] ? ROUND_C : '0);
	assign scaled = tick_s1.audible ? SCALED_W'(biased >>> msp_pkg::VOL_SHIFT) : '0;

	assign mix     = OFFSET_C + MIX_W'(scaled);
	assign shifted = mix >>> MIX_SHIFT;

	always_comb begin
		if (mix < 0) begin
			word = '0;
		end else if (shifted > MAX_C) begin
			word = msp_pkg::OUT_MAX;
		end else begin
			word = shifted[msp_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tick_s1.tick;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_q  <= word ^ msp_pkg::SIGN_FLIP;
			playing_q <= tick_s1.playing;
			cur_q     <= tick_s1.cur_buf;
		end
	end

	assign results.valid          = valid_q;
	assign results.sample_out     = sample_q;
	assign results.playing        = playing_q;
	assign results.current_buffer = cur_q;

endmodule

### hdl/multibuffer_sample_playback_mixer.sv
// A tick's result passes through the stage-one register and then the output register.
// Throughput: one item per cycle while the output is not stalled, set by the single sample
// memory access per item (a write or a tick read) and the stage-one / output register pair.
// Reset (arst_n low): buffers empty, playback stopped, position and buffer zero,
// step 4096, volume 256, not paused; the sample memory is not cleared.
module multibuffer_sample_playback_mixer #(
	parameter int NUM_BUFFERS  = msp_pkg::NUM_BUFFERS,
	parameter int BUFFER_DEPTH = msp_pkg::BUFFER_DEPTH,
	parameter int FRAC_BITS    = msp_pkg::FRAC_BITS,
	parameter int MIX_SHIFT    = msp_pkg::MIX_SHIFT
) (
	input  logic      clk,
	input  logic      arst_n,
	msp_in_if.sink    items,
	msp_out_if.source results,
	msp_cfg_if.sink   cfg
);

	localparam int STORE_DEPTH = NUM_BUFFERS * BUFFER_DEPTH;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	msp_pkg::tick_t               tick_s1;
	logic [msp_pkg::VOL_W-1:0]    vol;
	logic                         adv;
	logic                         ram_we, ram_re;
	logic [STORE_AW-1:0]          ram_waddr, ram_raddr;
	logic [msp_pkg::SAMPLE_W-1:0] ram_rdata;

	msp_ctrl #(
		.NUM_BUFFERS  (NUM_BUFFERS),
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg       (cfg),
		.adv       (adv),
		.tick_s1   (tick_s1),
		.vol       (vol),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	msp_ram #(
		.WIDTH (msp_pkg::SAMPLE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (items.sample_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	msp_mix #(
		.MIX_SHIFT (MIX_SHIFT)
	) u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_s1 (tick_s1),
		.rd_data (ram_rdata),
		.vol     (vol),
		.adv     (adv),
		.results (results)
	);

endmodule

### hdl/msp_checker.sv
`include "multibuffer_sample_playback_mixer_macros.svh"

module msp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         items_valid,
	input logic                         items_ready,
	input logic [msp_pkg::MODE_W-1:0]   items_mode,
	input logic                         results_valid,
	input logic                         results_ready,
	input logic [msp_pkg::SAMPLE_W-1:0] sample_out,
	input logic                         playing,
	input logic [msp_pkg::SEL_W-1:0]    current_buffer
);

	// a new result must come from an earlier accepted tick
	`MSP_ASSERT_SAME(a_result_from_tick, $rose(results_valid), $past(items_valid && items_ready && items_mode == msp_pkg::MODE_TICK, 2), "result without a preceding tick transfer")

	// stopped playback always sounds as silence
	`MSP_ASSERT_SAME(a_silent_when_stopped, results_valid && !playing, sample_out == '0, "nonzero output while playback stopped")

	// hold a stalled result
	`MSP_ASSERT_NEXT(a_hold_stalled, results_valid && !results_ready, results_valid && $stable(sample_out) && $stable(playing) && $stable(current_buffer), "stalled result changed")

endmodule

bind multibuffer_sample_playback_mixer msp_checker u_msp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.items_valid    (items.valid),
	.items_ready    (items.ready),
	.items_mode     (items.mode),
	.results_valid  (results.valid),
	.results_ready  (results.ready),
	.sample_out     (results.sample_out),
	.playing        (results.playing),
	.current_buffer (results.current_buffer)
);
